### src/bdir_pkg.sv
// shared types and constants for the bit-plane delta image restore block
// no dependencies; used by every module of the block
package bdir_pkg;

  localparam int NUM_LANES   = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int STRIDE_W    = 13;
  localparam int DEPTH_W     = 3;

  localparam logic [7:0] UNPACK_XOR   = 8'hFF;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd4;
  localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 3'd4;
  localparam logic [DEPTH_W-1:0]  DEPTH_MIN    = 3'd1;
  localparam logic [DEPTH_W-1:0]  DEPTH_MAX    = 3'd4;

  typedef logic [7:0] octet_t;
  typedef logic [NUM_LANES-1:0][7:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_STRIDE  = 4'd0,
    CFG_DEPTH_BYTES = 4'd1
  } cfg_idx_e;

  // control that travels with an item into the merge stage
  typedef struct packed {
    logic                 first_row;
    logic                 col_zero;
    logic [DEPTH_W-1:0]   depth;
  } merge_ctrl_t;

endpackage

### src/bdir_lane.sv
// one byte lane: gathers 2-bit group LANE from the four section bytes,
// unpacks it and forms the vertical delta sum; depends on bdir_pkg
module bdir_lane #(
  parameter int LANE = 0
) (
  input  bdir_pkg::word_t  planes_i,
  input  bdir_pkg::octet_t above_i,
  output bdir_pkg::octet_t unpacked_o,
  output bdir_pkg::octet_t vert_o
);

  bdir_pkg::octet_t raw;

  always_comb begin
    // section a supplies the top two bits, section d the lowest two
    raw = {planes_i[0][2*LANE +: 2], planes_i[1][2*LANE +: 2],
           planes_i[2][2*LANE +: 2], planes_i[3][2*LANE +: 2]};
    if (raw[0]) begin
      unpacked_o = {1'b0, raw[7:1]} ^ bdir_pkg::UNPACK_XOR;
    end else begin
      unpacked_o = {1'b0, raw[7:1]};
    end
    vert_o = unpacked_o + above_i;
  end

endmodule

### src/bdir_merge.sv
// merge stage: combines the lane results into one word, applying the
// horizontal delta on the first row; depends on bdir_pkg
module bdir_merge (
  input  bdir_pkg::word_t      unpacked_i,
  input  bdir_pkg::word_t      vert_i,
  input  bdir_pkg::word_t      prev_i,
  input  bdir_pkg::merge_ctrl_t ctrl_i,
  output bdir_pkg::word_t      word_o
);

  bdir_pkg::word_t  horiz;
  bdir_pkg::octet_t left;
  logic [1:0]       idx;

  always_comb begin
    horiz = '0;
    left  = '0;
    idx   = '0;
    // chain of at most four narrow adds: a byte may depend on an earlier one
    for (int k = 0; k < bdir_pkg::NUM_LANES; k++) begin
      if (k >= int'(ctrl_i.depth)) begin
        idx  = 2'(k - int'(ctrl_i.depth));
        left = horiz[idx];
      end else begin
        idx  = 2'(bdir_pkg::NUM_LANES + k - int'(ctrl_i.depth));
        left = prev_i[idx];
      end
      if (ctrl_i.col_zero && (k < int'(ctrl_i.depth))) begin
        horiz[k] = unpacked_i[k];
      end else begin
        horiz[k] = unpacked_i[k] + left;
      end
    end
    word_o = ctrl_i.first_row ? horiz : vert_i;
  end

endmodule

### src/bdir_line_store.sv
// line store: final words of the row above, one write and one read port,
// registered read with write-to-read forwarding; depends on bdir_pkg
module bdir_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  bdir_pkg::word_t wr_data_i,
  output bdir_pkg::word_t rd_data_o
);

  bdir_pkg::word_t mem [DEPTH];
  bdir_pkg::word_t rd_q;
  bdir_pkg::word_t fwd_data_q;
  logic            fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // a read at the address written in the same cycle takes the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

### src/bitplane_delta_image_restore.sv
// top level of the bit-plane de-interleave and 2-d delta restore block
// depends on bdir_pkg, bdir_lane, bdir_merge and bdir_line_store
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  plane_byte_a..d, frame_end
//   out      output     out_valid_o/out_stall_i out_byte0..3, frame_last
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction per cycle in and out when nothing stalls; a result reaches the
// outputs from the output register, which loads it after the taking edge has
// loaded stage 1 and the line store read
// the rate is set by the registered line store read and the first-row
// horizontal chain in the merge stage
// reset clears row position, first-row flag and pipeline valids; the line
// store has no clearing pass and holds garbage until a row is written
// out stall backs up into the pipeline; in_stall_o rises only while a result
// waits in the output register and another item sits behind it
module bitplane_delta_image_restore #(
  parameter int MAX_STRIDE = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input transactions
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       plane_byte_a_i,
  input  logic [7:0]                       plane_byte_b_i,
  input  logic [7:0]                       plane_byte_c_i,
  input  logic [7:0]                       plane_byte_d_i,
  input  logic                             frame_end_i,
  // result transactions
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       out_byte0_o,
  output logic [7:0]                       out_byte1_o,
  output logic [7:0]                       out_byte2_o,
  output logic [7:0]                       out_byte3_o,
  output logic                             frame_last_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bdir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bdir_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int LINE_WORDS = MAX_STRIDE / 4;
  localparam int AW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;

  // configuration registers
  logic [bdir_pkg::STRIDE_W-1:0] row_stride_q;
  logic [bdir_pkg::DEPTH_W-1:0]  depth_q;
  logic [bdir_pkg::DEPTH_W-1:0]  depth_eff;

  // row position tracking, updated as each item is taken
  logic [AW-1:0] col_q, col_d, col_eff;
  logic          first_q, first_d;
  logic [AW:0]   wpr;
  logic [AW:0]   col_next;
  logic [31:0]   stride_words;

  // stage 1: item waiting for its line store word
  logic                 s1_valid_q;
  bdir_pkg::word_t      s1_planes_q;
  logic                 s1_frame_q;
  logic [AW-1:0]        s1_col_q;
  logic                 s1_first_q;
  logic                 s1_col_zero_q;

  // output register
  logic                 out_valid_q;
  bdir_pkg::word_t      out_word_q;
  logic                 out_last_q;

  // last final word, source of the horizontal delta across words
  bdir_pkg::word_t      prev_q;

  logic                 in_ready, in_acc, s1_adv;
  bdir_pkg::word_t      above, unpacked, vert, merged;
  bdir_pkg::merge_ctrl_t mctrl;

  // handshake control
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_ready   = !s1_valid_q || s1_adv;
  assign in_stall_o = !in_ready;
  assign in_acc     = in_valid_i && in_ready;
  assign cfg_ready_o = 1'b1;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q <= bdir_pkg::STRIDE_RESET;
      depth_q      <= bdir_pkg::DEPTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bdir_pkg::cfg_idx_e'(cfg_index_i))
        bdir_pkg::CFG_ROW_STRIDE:  row_stride_q <= cfg_data_i[bdir_pkg::STRIDE_W-1:0];
        bdir_pkg::CFG_DEPTH_BYTES: depth_q      <= cfg_data_i[bdir_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // depth clamped to one..four
  always_comb begin
    if (depth_q < bdir_pkg::DEPTH_MIN) begin
      depth_eff = bdir_pkg::DEPTH_MIN;
    end else if (depth_q > bdir_pkg::DEPTH_MAX) begin
      depth_eff = bdir_pkg::DEPTH_MAX;
    end else begin
      depth_eff = depth_q;
    end
  end

  // words per row, clamped to one..line store depth
  always_comb begin
    stride_words = 32'(row_stride_q[bdir_pkg::STRIDE_W-1:2]);
    if (stride_words == 32'd0) begin
      stride_words = 32'd1;
    end
    if (stride_words > 32'(LINE_WORDS)) begin
      stride_words = 32'(LINE_WORDS);
    end
    wpr = stride_words[AW:0];
  end

  // column position of the item being taken, and where the next one lands
  always_comb begin
    // a position past a shrunk row restarts at zero
    col_eff  = ({1'b0, col_q} >= wpr) ? '0 : col_q;
    col_next = {1'b0, col_eff} + {{AW{1'b0}}, 1'b1};
    col_d    = col_q;
    first_d  = first_q;
    if (in_acc) begin
      if (frame_end_i) begin
        col_d   = '0;
        first_d = 1'b1;
      end else if (col_next >= wpr) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = col_next[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_planes_q   <= {plane_byte_d_i, plane_byte_c_i, plane_byte_b_i, plane_byte_a_i};
      s1_frame_q    <= frame_end_i;
      s1_col_q      <= col_eff;
      s1_first_q    <= first_q;
      s1_col_zero_q <= (col_eff == '0);
    end
  end

  // line store: read when an item is taken, written as it leaves stage 1
  bdir_line_store #(
    .DEPTH (LINE_WORDS),
    .AW    (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_eff),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (merged),
    .rd_data_o (above)
  );

  // four byte lanes side by side
  for (genvar g = 0; g < bdir_pkg::NUM_LANES; g++) begin : g_lane
    bdir_lane #(
      .LANE (g)
    ) u_lane (
      .planes_i   (s1_planes_q),
      .above_i    (above[g]),
      .unpacked_o (unpacked[g]),
      .vert_o     (vert[g])
    );
  end

  always_comb begin
    mctrl.first_row = s1_first_q;
    mctrl.col_zero  = s1_col_zero_q;
    mctrl.depth     = depth_eff;
  end

  bdir_merge u_merge (
    .unpacked_i (unpacked),
    .vert_i     (vert),
    .prev_i     (prev_q),
    .ctrl_i     (mctrl),
    .word_o     (merged)
  );

  // previous word returns to zero after the end of an image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (s1_adv) begin
      prev_q <= s1_frame_q ? '0 : merged;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q <= merged;
      out_last_q <= s1_frame_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte0_o  = out_word_q[0];
  assign out_byte1_o  = out_word_q[1];
  assign out_byte2_o  = out_word_q[2];
  assign out_byte3_o  = out_word_q[3];
  assign frame_last_o = out_last_q;

endmodule

### src/bdir_checker.sv
// port-level checker for the bit-plane delta image restore block
// bound to bitplane_delta_image_restore; watches handshake and result ports only
module bdir_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [7:0]                       out_byte0_o,
  input logic [7:0]                       out_byte1_o,
  input logic [7:0]                       out_byte2_o,
  input logic [7:0]                       out_byte3_o,
  input logic                             frame_last_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a result pending at the output is not withdrawn
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // a stalled result keeps its payload
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte0_o) && $stable(out_byte1_o)
      && $stable(out_byte2_o) && $stable(out_byte3_o) && $stable(frame_last_o))
    else $error("stalled result payload changed");

  // input backs up only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a fresh result follows an earlier input transaction
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 2))
    else $error("result without a matching input transaction");

endmodule

bind bitplane_delta_image_restore bdir_checker u_bdir_checker (.*);

### tb/bdir_restore_checker.sv
`timescale 1ns / 1ps
// result checker for the bit-plane delta image restore block
// depends on bdir_pkg; watches the in, out and cfg channels of the block
module bdir_restore_checker #(
  parameter int MAX_STRIDE = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      plane_byte_a_i,
  input  logic [7:0]                      plane_byte_b_i,
  input  logic [7:0]                      plane_byte_c_i,
  input  logic [7:0]                      plane_byte_d_i,
  input  logic                            frame_end_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [7:0]                      out_byte0_i,
  input  logic [7:0]                      out_byte1_i,
  input  logic [7:0]                      out_byte2_i,
  input  logic [7:0]                      out_byte3_i,
  input  logic                            frame_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [bdir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bdir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              error_count_o,
  output int                              pending_o
);

  localparam int LINE_WORDS = MAX_STRIDE / 4;

  typedef struct packed {
    bdir_pkg::word_t bytes;
    logic            last;
  } restored_t;

  logic [bdir_pkg::STRIDE_W-1:0] row_stride_q;
  logic [bdir_pkg::DEPTH_W-1:0]  depth_q;
  int                            column_word;
  logic                          first_row;
  bdir_pkg::word_t               prev_word;
  bdir_pkg::word_t               line_words [LINE_WORDS];
  restored_t                     restored_q [$];
  int                            errors = 0;

  // restore one word from four section bytes and advance the row position
  function automatic restored_t restore_planes(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                               logic [7:0] d, logic fe);
    restored_t       r;
    bdir_pkg::word_t fin;
    bdir_pkg::word_t above;
    logic [7:0]      raw;
    int              wpr;
    int              dep;
    int              k;
    wpr = row_stride_q >> 2;
    if (wpr < 1) wpr = 1;
    if (wpr > LINE_WORDS) wpr = LINE_WORDS;
    dep = depth_q;
    if (dep < 1) dep = 1;
    if (dep > 4) dep = 4;
    if (column_word >= wpr) column_word = 0;
    for (k = 0; k < 4; k++) begin
      raw = {a[2*k +: 2], b[2*k +: 2], c[2*k +: 2], d[2*k +: 2]};
      fin[k] = raw[0] ? ((raw >> 1) ^ bdir_pkg::UNPACK_XOR) : (raw >> 1);
    end
    if (first_row) begin
      for (k = 0; k < 4; k++) begin
        if (column_word * 4 + k >= dep) begin
          if (k >= dep) fin[k] = fin[k] + fin[k-dep];
          else fin[k] = fin[k] + prev_word[4+k-dep];
        end
      end
    end else begin
      above = line_words[column_word];
      for (k = 0; k < 4; k++) fin[k] = fin[k] + above[k];
    end
    line_words[column_word] = fin;
    prev_word = fin;
    r.bytes = fin;
    r.last  = fe;
    if (fe) begin
      column_word = 0;
      first_row   = 1'b1;
      prev_word   = '0;
    end else if (column_word + 1 >= wpr) begin
      column_word = 0;
      first_row   = 1'b0;
    end else begin
      column_word++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    restored_t       exp;
    bdir_pkg::word_t act;
    int              k;
    if (!rst_ni) begin
      row_stride_q = bdir_pkg::STRIDE_RESET;
      depth_q      = bdir_pkg::DEPTH_RESET;
      column_word  = 0;
      first_row    = 1'b1;
      prev_word    = '0;
      restored_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bdir_pkg::CFG_ROW_STRIDE)
          row_stride_q = cfg_data_i[bdir_pkg::STRIDE_W-1:0];
        else if (cfg_index_i == bdir_pkg::CFG_DEPTH_BYTES)
          depth_q = cfg_data_i[bdir_pkg::DEPTH_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        act = {out_byte3_i, out_byte2_i, out_byte1_i, out_byte0_i};
        if (restored_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, got %h last %b",
                   $time, act, frame_last_i);
        end else begin
          exp = restored_q.pop_front();
          for (k = 0; k < 4; k++) begin
            if (act[k] !== exp.bytes[k]) begin
              errors++;
              $display("%0t: out_byte%0d expected %h got %h", $time, k, exp.bytes[k], act[k]);
            end
          end
          if (frame_last_i !== exp.last) begin
            errors++;
            $display("%0t: frame_last expected %b got %b", $time, exp.last, frame_last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        restored_q.push_back(restore_planes(plane_byte_a_i, plane_byte_b_i, plane_byte_c_i,
                                            plane_byte_d_i, frame_end_i));
      pending_o <= restored_q.size();
    end
    error_count_o <= errors;
  end

endmodule

### tb/bitplane_delta_image_restore_tb.sv
`timescale 1ns / 1ps
// top of the bit-plane delta image restore testbench: clock, reset, stimulus, verdict
// depends on bdir_pkg, bitplane_delta_image_restore and bdir_restore_checker
module bitplane_delta_image_restore_tb;

  localparam int MAX_STRIDE   = 4096;
  localparam int LINE_WORDS   = MAX_STRIDE / 4;
  localparam int CFG_W        = bdir_pkg::CFG_DATA_W;
  localparam int RANDOM_ITEMS = 340;
  // receiver holds off once after this many result transactions
  localparam int PRESSURE_AT  = 150;
  localparam int PRESSURE_LEN = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam longint TIMEOUT_NS = 64'd5_000_000;
  // an index that names no register; the block must ignore writes to it
  localparam logic [bdir_pkg::CFG_IDX_W-1:0] UNUSED_INDEX = 4'd9;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      plane_a = '0;
  logic [7:0]                      plane_b = '0;
  logic [7:0]                      plane_c = '0;
  logic [7:0]                      plane_d = '0;
  logic                            frame_end = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_byte0;
  logic [7:0]                      out_byte1;
  logic [7:0]                      out_byte2;
  logic [7:0]                      out_byte3;
  logic                            frame_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bdir_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]                cfg_data = '0;
  int                              error_count;
  int                              pending;

  // stride the block holds now, tracked so mid-image writes only shrink rows
  logic [bdir_pkg::STRIDE_W-1:0]   cur_stride = bdir_pkg::STRIDE_RESET;
  int                              items_sent = 0;
  int                              send_quiet = 0;
  int                              sink_quiet = 0;

  bitplane_delta_image_restore #(
    .MAX_STRIDE(MAX_STRIDE)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .plane_byte_a_i(plane_a),
    .plane_byte_b_i(plane_b),
    .plane_byte_c_i(plane_c),
    .plane_byte_d_i(plane_d),
    .frame_end_i   (frame_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte0_o   (out_byte0),
    .out_byte1_o   (out_byte1),
    .out_byte2_o   (out_byte2),
    .out_byte3_o   (out_byte3),
    .frame_last_o  (frame_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bdir_restore_checker #(
    .MAX_STRIDE(MAX_STRIDE)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .plane_byte_a_i(plane_a),
    .plane_byte_b_i(plane_b),
    .plane_byte_c_i(plane_c),
    .plane_byte_d_i(plane_d),
    .frame_end_i   (frame_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte0_i   (out_byte0),
    .out_byte1_i   (out_byte1),
    .out_byte2_i   (out_byte2),
    .out_byte3_i   (out_byte3),
    .frame_last_i  (frame_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle cycles before the next transaction; now and then a burst with no idling
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 23) == 0) begin
      quiet = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // words per row as the block sees a stride: clamped to one and to the line store
  function automatic int row_words(logic [bdir_pkg::STRIDE_W-1:0] stride);
    int w;
    w = stride >> 2;
    if (w < 1) w = 1;
    if (w > LINE_WORDS) w = LINE_WORDS;
    return w;
  endfunction

  // one input transaction; valid stays high afterwards unless the next one idles first
  task automatic send_planes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input logic fe);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    plane_a   <= a;
    plane_b   <= b;
    plane_c   <= c;
    plane_d   <= d;
    frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random(input logic fe);
    send_planes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), fe);
  endtask

  // stop offering and wait until every expected result is out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == bdir_pkg::CFG_ROW_STRIDE) cur_stride = data[bdir_pkg::STRIDE_W-1:0];
  endtask

  // one image under a fresh setting; mostly whole rows, sometimes cut short
  // or with the rows shrunk part way through
  task automatic random_frame();
    int               sel;
    int               mode;
    int               total;
    int               cut;
    int               i;
    logic [CFG_W-1:0] stride;
    logic [CFG_W-1:0] depth;
    settle();
    sel = $urandom_range(0, 9);
    if (sel == 0) stride = CFG_W'($urandom_range(65, 512));
    else stride = CFG_W'($urandom_range(0, 64));
    depth = CFG_W'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: write_reg(bdir_pkg::CFG_ROW_STRIDE, stride);
      1: write_reg(bdir_pkg::CFG_DEPTH_BYTES, depth);
      default: begin
        write_reg(bdir_pkg::CFG_ROW_STRIDE, stride);
        write_reg(bdir_pkg::CFG_DEPTH_BYTES, depth);
      end
    endcase
    total = row_words(cur_stride) * ((sel == 0) ? $urandom_range(1, 2) : $urandom_range(1, 6));
    mode  = $urandom_range(0, 7);
    cut   = $urandom_range(1, total);
    for (i = 0; i < total; i++) begin
      if (mode == 1 && i == cut - 1 && i > 0) begin
        // narrower rows mid-image: only lines already written get read back
        settle();
        write_reg(bdir_pkg::CFG_ROW_STRIDE, CFG_W'($urandom_range(0, cur_stride)));
        if ($urandom_range(0, 1))
          write_reg(bdir_pkg::CFG_DEPTH_BYTES, CFG_W'($urandom_range(0, 7)));
      end
      if (mode == 0 && i == cut - 1) begin
        // image closed early, in the middle of a row
        send_random(1'b1);
        break;
      end
      send_random(i == total - 1);
    end
  endtask

  // reset held from the start of simulation, released once
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && taken >= PRESSURE_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_LEN) @(posedge clk);
      end
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int guard;
    int i;
    int random_start;
    wait (rst_n);
    repeat (2) @(posedge clk);

    // reset setting: one-word rows, depth four; every later row adds the one above
    send_planes(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_planes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_planes(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
    send_planes(8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0);
    send_planes(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);

    // two-word rows, depth one: longest horizontal chain in the first row
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd8);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd1);
    for (i = 0; i < 5; i++) send_random(i == 4);

    // stride below four gives one-word rows; depth zero acts as one
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd3);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd0);
    for (i = 0; i < 3; i++) send_random(i == 2);

    // stride not a multiple of four rounds down; depth above four acts as four
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd10);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd7);
    for (i = 0; i < 3; i++) send_random(i == 2);

    // four-word rows, then shrink to two while sitting at column two of row one
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd16);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd2);
    for (i = 0; i < 6; i++) send_random(1'b0);
    settle();
    write_reg(UNUSED_INDEX, 13'h1FFF);
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd8);
    for (i = 0; i < 2; i++) send_random(i == 1);

    // random images
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) random_frame();

    // largest legal stride, a short image
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'd4096);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd4);
    for (i = 0; i < 8; i++) send_random(i == 7);

    // stride above the line store: rows clamp to the full store, a short image
    settle();
    write_reg(bdir_pkg::CFG_ROW_STRIDE, 13'h1FFF);
    write_reg(bdir_pkg::CFG_DEPTH_BYTES, 13'd3);
    for (i = 0; i < 8; i++) send_random(i == 7);

    // drain, then a few more cycles for stray results
    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected transactions never arrived", $time, pending);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop if a handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
